// ===== hdl/ordered_array_list_engine_macros.svh =====
// Assertion macros shared by the checker of the ordered array list engine.
// Depends on nothing; included by the checker file.
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define OALE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OALE_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hdl/oale_pkg.sv =====
// Package of the ordered array list engine: opcodes, status codes, states,
// controller commands and the request and response payload types. Depends on nothing.
package oale_pkg;
   localparam int DefaultCapacity = 64;
   localparam int OpWidth = 4;
   localparam int ValueWidth = 32;
   localparam int PosWidth = 6;
   localparam int StatusWidth = 3;
   localparam int CountWidth = 7;

   typedef enum logic [3:0] {
      OP_CLEAR = 4'd0, OP_INS_FIRST = 4'd1, OP_INS_AT = 4'd2, OP_INS_LAST = 4'd3,
      OP_DEL_FIRST = 4'd4, OP_DEL_AT = 4'd5, OP_DEL_LAST = 4'd6, OP_SEARCH = 4'd7,
      OP_EXTREMES = 4'd8, OP_SORT_UP = 4'd9, OP_SORT_DOWN = 4'd10
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_BADIDX = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_SHUP_RD, S_SHUP_WR, S_SHDN_RD, S_SHDN_CAP, S_SHDN_CHK,
      S_SHDN_WR, S_SCAN_RD, S_SCAN_CHK, S_SO_OUT, S_SO_CUR, S_SO_CHK, S_SO_CMP,
      S_SO_PUT, S_DONE
   } state_type;

   // Datapath commands issued by the controller.
   typedef enum logic [3:0] {
      C_NONE, C_START, C_RD_UP, C_WR_UP, C_PUT_V, C_RD_I, C_DN_CAP, C_RD_NEXT,
      C_WR_DN, C_DN_END, C_SCAN_CHK, C_SO_CUR, C_SO_RD, C_SO_MOVE, C_SO_PUT
   } cmd_type;

   typedef struct packed {
      logic at_limit;     // insert walk reached the insert position
      logic tail_done;    // walk index sits on the last element
      logic hit;          // element read equals the searched value
      logic sort_stop;    // inner sort walk reached the front
      logic outer_done;   // sort outer index reached count
      logic move;         // sort element must move up one place
   } stat_type;

   typedef struct packed {
      logic [OpWidth-1:0]           opcode;
      logic signed [ValueWidth-1:0] value;
      logic [PosWidth-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [StatusWidth-1:0]       status;
      logic signed [ValueWidth-1:0] read_value;
      logic signed [ValueWidth-1:0] min_value;
      logic [PosWidth-1:0]          found_index;
      logic [CountWidth-1:0]        count;
   } rsp_type;
endpackage

// ===== hdl/oale_chan_if.sv =====
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing.
interface oale_chan_if #(parameter type T = logic) (input logic clock);
   logic valid;
   logic ready;
   T     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/oale_datapath.sv =====
// Datapath of the list engine: element memory, count, walk indexes, result.
// Depends on oale_pkg.
module oale_datapath #(
   parameter int Capacity = oale_pkg::DefaultCapacity
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  oale_pkg::cmd_type                    cmd,
   input  logic [oale_pkg::OpWidth-1:0]         op,
   input  logic [oale_pkg::ValueWidth-1:0]      value,
   input  logic [oale_pkg::PosWidth-1:0]        position,
   output oale_pkg::stat_type                   stat,
   output logic                                 early,
   output logic [oale_pkg::StatusWidth-1:0]     status,
   output logic [oale_pkg::ValueWidth-1:0]      read_value,
   output logic [oale_pkg::ValueWidth-1:0]      min_value,
   output logic [oale_pkg::PosWidth-1:0]        found_index,
   output logic [oale_pkg::CountWidth-1:0]      count
);
   import oale_pkg::*;
   localparam int AW = $clog2(Capacity);
   localparam int IW = ($clog2(Capacity + 1) > CountWidth) ? $clog2(Capacity + 1)
                                                           : CountWidth;
   localparam logic [IW-1:0] One = IW'(1);

   logic [ValueWidth-1:0] mem [Capacity];
   logic [ValueWidth-1:0] rdata_ff;
   logic [IW-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in, lim_ff, lim_in;
   logic [ValueWidth-1:0] cur_ff, cur_in, mx_ff, mx_in, mn_ff, mn_in;
   logic [StatusWidth-1:0] st_ff, st_in, chk_st;
   logic [PosWidth-1:0] fi_ff, fi_in;
   logic we;
   logic [AW-1:0] wa, ra;
   logic [ValueWidth-1:0] wd;
   logic [IW-1:0] pos_w, ins_pos, del_pos;
   logic full, empty, asc;

   assign pos_w = IW'(position);
   assign full = (cnt_ff == IW'(Capacity));
   assign empty = (cnt_ff == '0);
   assign asc = (op == OP_SORT_UP);

   always_comb begin
      ins_pos = (op == OP_INS_FIRST) ? '0 : (op == OP_INS_LAST) ? cnt_ff : pos_w;
      del_pos = (op == OP_DEL_FIRST) ? '0 : (op == OP_DEL_LAST) ? cnt_ff - One : pos_w;
   end

   always_comb begin
      early = 1'b1;
      chk_st = ST_OK;
      case (op)
         OP_INS_FIRST, OP_INS_AT, OP_INS_LAST: begin
            if (full) chk_st = ST_FULL;
            else if (op == OP_INS_AT && pos_w > cnt_ff) chk_st = ST_BADIDX;
            else early = 1'b0;
         end
         OP_DEL_FIRST, OP_DEL_AT, OP_DEL_LAST: begin
            if (empty) chk_st = ST_EMPTY;
            else if (op == OP_DEL_AT && pos_w >= cnt_ff) chk_st = ST_BADIDX;
            else early = 1'b0;
         end
         OP_SEARCH: begin
            chk_st = ST_NOTFOUND;
            early = empty;
         end
         OP_EXTREMES: begin
            if (empty) chk_st = ST_EMPTY;
            else early = 1'b0;
         end
         OP_SORT_UP, OP_SORT_DOWN: early = (cnt_ff < IW'(2));
         default: early = 1'b1;
      endcase
   end

   always_comb begin
      stat.at_limit = (i_ff == lim_ff);
      stat.tail_done = (i_ff + One >= cnt_ff);
      stat.hit = (rdata_ff == value);
      stat.sort_stop = (j_ff == '0);
      stat.outer_done = (i_ff >= cnt_ff);
      stat.move = asc ? ($signed(rdata_ff) > $signed(cur_ff))
                      : ($signed(rdata_ff) < $signed(cur_ff));
   end

   always_comb begin
      cnt_in = cnt_ff; i_in = i_ff; j_in = j_ff; lim_in = lim_ff; cur_in = cur_ff;
      mx_in = mx_ff; mn_in = mn_ff; fi_in = fi_ff; st_in = st_ff;
      we = 1'b0; wa = AW'(i_ff); wd = rdata_ff; ra = AW'(i_ff);
      case (cmd)
         C_START: begin
            st_in = chk_st;
            mx_in = '0; mn_in = '0; fi_in = '0;
            if (op == OP_CLEAR) cnt_in = '0;
            case (op)
               OP_INS_FIRST, OP_INS_AT, OP_INS_LAST: begin
                  i_in = cnt_ff; lim_in = ins_pos;
               end
               OP_DEL_FIRST, OP_DEL_AT, OP_DEL_LAST: i_in = del_pos;
               OP_SORT_UP, OP_SORT_DOWN: i_in = One;
               default: i_in = '0;
            endcase
         end
         C_RD_UP: ra = AW'(i_ff - One);
         C_WR_UP: begin
            we = 1'b1; wa = AW'(i_ff); wd = rdata_ff; i_in = i_ff - One;
         end
         C_PUT_V: begin
            we = 1'b1; wa = AW'(lim_ff); wd = value; cnt_in = cnt_ff + One;
         end
         C_RD_I: ra = AW'(i_ff);
         C_DN_CAP: mx_in = rdata_ff;
         C_RD_NEXT: ra = AW'(i_ff + One);
         C_WR_DN: begin
            we = 1'b1; wa = AW'(i_ff); wd = rdata_ff; i_in = i_ff + One;
         end
         C_DN_END: cnt_in = cnt_ff - One;
         C_SCAN_CHK: begin
            if (op == OP_SEARCH) begin
               if (stat.hit) begin
                  st_in = ST_OK; fi_in = PosWidth'(i_ff);
               end
            end else if (i_ff == '0) begin
               mx_in = rdata_ff; mn_in = rdata_ff;
            end else begin
               if ($signed(rdata_ff) > $signed(mx_ff)) mx_in = rdata_ff;
               if ($signed(rdata_ff) < $signed(mn_ff)) mn_in = rdata_ff;
            end
            i_in = i_ff + One;
         end
         C_SO_CUR: begin
            cur_in = rdata_ff; j_in = i_ff;
         end
         C_SO_RD: ra = AW'(j_ff - One);
         C_SO_MOVE: begin
            we = 1'b1; wa = AW'(j_ff); wd = rdata_ff; j_in = j_ff - One;
         end
         C_SO_PUT: begin
            we = 1'b1; wa = AW'(j_ff); wd = cur_ff; i_in = i_ff + One;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rdata_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      i_ff <= i_in; j_ff <= j_in; lim_ff <= lim_in; cur_ff <= cur_in;
      mx_ff <= mx_in; mn_ff <= mn_in; fi_ff <= fi_in; st_ff <= st_in;
   end

   assign status = st_ff;
   assign read_value = mx_ff;
   assign min_value = mn_ff;
   assign found_index = fi_ff;
   assign count = CountWidth'(cnt_ff);
endmodule

// ===== hdl/oale_control.sv =====
// Controller of the list engine: sequences each operation over the datapath.
// Depends on oale_pkg.
module oale_control (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   output logic                          out_valid,
   input  logic                          out_ready,
   input  logic [oale_pkg::OpWidth-1:0]  op,
   input  oale_pkg::stat_type            stat,
   input  logic                          early,
   output logic                          load,
   output oale_pkg::cmd_type             cmd
);
   import oale_pkg::*;
   state_type state_ff, state_in;
   logic ins, del, scan, srt, srch;

   assign ins = op inside {OP_INS_FIRST, OP_INS_AT, OP_INS_LAST};
   assign del = op inside {OP_DEL_FIRST, OP_DEL_AT, OP_DEL_LAST};
   assign scan = op inside {OP_SEARCH, OP_EXTREMES};
   assign srt = op inside {OP_SORT_UP, OP_SORT_DOWN};
   assign srch = (op == OP_SEARCH);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (in_valid) state_in = S_START;
         S_START: begin
            if (early) state_in = S_DONE;
            else if (ins) state_in = S_SHUP_RD;
            else if (del) state_in = S_SHDN_RD;
            else if (scan) state_in = S_SCAN_RD;
            else if (srt) state_in = S_SO_OUT;
            else state_in = S_DONE;
         end
         S_SHUP_RD: state_in = stat.at_limit ? S_DONE : S_SHUP_WR;
         S_SHUP_WR: state_in = S_SHUP_RD;
         S_SHDN_RD: state_in = S_SHDN_CAP;
         S_SHDN_CAP: state_in = S_SHDN_CHK;
         S_SHDN_CHK: state_in = stat.tail_done ? S_DONE : S_SHDN_WR;
         S_SHDN_WR: state_in = S_SHDN_CHK;
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if ((srch && stat.hit) || stat.tail_done) state_in = S_DONE;
            else state_in = S_SCAN_RD;
         end
         S_SO_OUT: state_in = stat.outer_done ? S_DONE : S_SO_CUR;
         S_SO_CUR: state_in = S_SO_CHK;
         S_SO_CHK: state_in = stat.sort_stop ? S_SO_PUT : S_SO_CMP;
         S_SO_CMP: state_in = stat.move ? S_SO_CHK : S_SO_PUT;
         S_SO_PUT: state_in = S_SO_OUT;
         S_DONE: if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = C_NONE;
      in_ready = (state_ff == S_IDLE);
      out_valid = (state_ff == S_DONE);
      load = (state_ff == S_IDLE) && in_valid;
      case (state_ff)
         S_START: cmd = C_START;
         S_SHUP_RD: cmd = stat.at_limit ? C_PUT_V : C_RD_UP;
         S_SHUP_WR: cmd = C_WR_UP;
         S_SHDN_RD: cmd = C_RD_I;
         S_SHDN_CAP: cmd = C_DN_CAP;
         S_SHDN_CHK: cmd = stat.tail_done ? C_DN_END : C_RD_NEXT;
         S_SHDN_WR: cmd = C_WR_DN;
         S_SCAN_RD: cmd = C_RD_I;
         S_SCAN_CHK: cmd = C_SCAN_CHK;
         S_SO_OUT: cmd = stat.outer_done ? C_NONE : C_RD_I;
         S_SO_CUR: cmd = C_SO_CUR;
         S_SO_CHK: cmd = stat.sort_stop ? C_NONE : C_SO_RD;
         S_SO_CMP: cmd = stat.move ? C_SO_MOVE : C_NONE;
         S_SO_PUT: cmd = C_SO_PUT;
         default: cmd = C_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== hdl/ordered_array_list_engine.sv =====
// Ordered array list engine: a packed list of signed 32-bit elements in one
// memory with one read and one write a cycle. One item at a time; the result
// waits in the output registers until its transfer, and the next request is taken
// in the cycle after that transfer. An insert or a delete walks the elements from
// its position to the end (insert-first uses position 0, insert-last count, delete-last
// count-1), search and extremes read the elements in turn, and a sort walks each
// element and moves the larger or smaller ones up. The result is held while
// rsp.ready is low.
module ordered_array_list_engine #(
   parameter int ListCapacity = oale_pkg::DefaultCapacity
) (
   input logic clock,
   input logic reset,
   oale_chan_if.sink   req,
   oale_chan_if.source rsp
);
   import oale_pkg::*;
   logic [OpWidth-1:0] op_ff;
   logic [ValueWidth-1:0] val_ff;
   logic [PosWidth-1:0] pos_ff;
   logic load, early;
   cmd_type cmd;
   stat_type stat;
   logic [StatusWidth-1:0] st_w;
   logic [ValueWidth-1:0] rv_w, mn_w;
   logic [PosWidth-1:0] fi_w;
   logic [CountWidth-1:0] cnt_w;

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff <= req.payload.opcode;
         val_ff <= req.payload.value;
         pos_ff <= req.payload.position;
      end
   end

   oale_control u_ctl (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .op(op_ff), .stat, .early,
      .load, .cmd
   );

   oale_datapath #(.Capacity(ListCapacity)) u_dp (
      .clock, .reset, .cmd, .op(op_ff), .value(val_ff), .position(pos_ff),
      .stat, .early, .status(st_w), .read_value(rv_w), .min_value(mn_w),
      .found_index(fi_w), .count(cnt_w)
   );

   assign rsp.payload = rsp_type'{status: st_w, read_value: rv_w, min_value: mn_w,
                                  found_index: fi_w, count: cnt_w};
endmodule

// ===== hdl/oale_checker.sv =====
// Port checker of the list engine, bound to the top level.
// Depends on oale_pkg and the macro header.
`include "ordered_array_list_engine_macros.svh"
module oale_checker #(
   parameter int Capacity = oale_pkg::DefaultCapacity
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [oale_pkg::CountWidth-1:0] rsp_count,
   input logic [oale_pkg::StatusWidth-1:0] rsp_status
);
   import oale_pkg::*;
   `OALE_ASSERT(a_cnt, clock, reset, rsp_valid |-> rsp_count <= CountWidth'(Capacity), "count too large")
   `OALE_ASSERT(a_st, clock, reset, rsp_valid |-> rsp_status <= ST_NOTFOUND, "bad status")
   `OALE_ASSERT(a_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_status), "rsp dropped")
   `OALE_ASSERT_NR(a_rst, clock, reset |=> !rsp_valid, "valid after reset")
endmodule

bind ordered_array_list_engine oale_checker #(.Capacity(ListCapacity)) u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_count(rsp.payload.count), .rsp_status(rsp.payload.status)
);

// ===== tb/sv/ordered_array_list_engine_tb.sv =====
// Testbench of the ordered array list engine: a directed table, then random
// traffic, checked against the table's expected responses or a behavioral list model kept inside this module.
// Depends on oale_pkg, oale_chan_if and ordered_array_list_engine.
module ordered_array_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import oale_pkg::*;

   typedef struct {
      req_type op;
      bit      typed;
      rsp_type rsp;
   } table_row_type;

   localparam int Capacity = DefaultCapacity;
   localparam int RandomOps = 1250;
   localparam int QuietTail = 150;
   localparam longint CycleLimit = 30_000_000;
   localparam logic [3:0] OpUnusedLo = 4'd11;
   localparam logic [3:0] OpUnusedHi = 4'd15;
   localparam logic signed [31:0] MinInt = 32'sh8000_0000;
   localparam logic signed [31:0] MaxInt = 32'sh7fff_ffff;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   oale_chan_if #(.T(req_type)) req_ch (clock);
   oale_chan_if #(.T(rsp_type)) rsp_ch (clock);

   ordered_array_list_engine dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   logic signed [31:0] list_store [Capacity];
   int list_len = 0;
   rsp_type pending_rsp [$];
   int mismatches = 0;
   int ops_sent = 0;
   int rsps_seen = 0;
   bit quiet = 1'b0;
   longint cycles = 0;

   function automatic rsp_type list_apply(req_type r);
      rsp_type o;
      logic signed [31:0] cur;
      int j;
      int p;
      o = '{status: ST_OK, read_value: '0, min_value: '0, found_index: '0, count: '0};
      p = r.position;
      case (r.opcode)
         OP_CLEAR: list_len = 0;
         OP_INS_FIRST, OP_INS_AT, OP_INS_LAST: begin
            if (list_len >= Capacity) begin
               o.status = ST_FULL;
            end else begin
               if (r.opcode == OP_INS_FIRST) p = 0;
               else if (r.opcode == OP_INS_LAST) p = list_len;
               if (p > list_len) begin
                  o.status = ST_BADIDX;
               end else begin
                  for (j = list_len; j > p; j--) list_store[j] = list_store[j - 1];
                  list_store[p] = r.value;
                  list_len++;
               end
            end
         end
         OP_DEL_FIRST, OP_DEL_AT, OP_DEL_LAST: begin
            if (list_len == 0) begin
               o.status = ST_EMPTY;
            end else begin
               if (r.opcode == OP_DEL_FIRST) p = 0;
               else if (r.opcode == OP_DEL_LAST) p = list_len - 1;
               if (p >= list_len) begin
                  o.status = ST_BADIDX;
               end else begin
                  o.read_value = list_store[p];
                  for (j = p; j + 1 < list_len; j++) list_store[j] = list_store[j + 1];
                  list_len--;
               end
            end
         end
         OP_SEARCH: begin
            o.status = ST_NOTFOUND;
            for (j = list_len - 1; j >= 0; j--) begin
               if (list_store[j] == r.value) begin
                  o.status = ST_OK;
                  o.found_index = j[5:0];
               end
            end
         end
         OP_EXTREMES: begin
            if (list_len == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.read_value = list_store[0];
               o.min_value = list_store[0];
               for (j = 1; j < list_len; j++) begin
                  if (list_store[j] > o.read_value) o.read_value = list_store[j];
                  if (list_store[j] < o.min_value) o.min_value = list_store[j];
               end
            end
         end
         OP_SORT_UP, OP_SORT_DOWN: begin
            for (int i = 1; i < list_len; i++) begin
               cur = list_store[i];
               j = i;
               while (j > 0 && (r.opcode == OP_SORT_UP ? list_store[j - 1] > cur
                                                       : list_store[j - 1] < cur)) begin
                  list_store[j] = list_store[j - 1];
                  j--;
               end
               list_store[j] = cur;
            end
         end
         default: ;
      endcase
      o.count = list_len[6:0];
      return o;
   endfunction

   task automatic send_op(req_type r, bit typed, rsp_type typed_rsp);
      rsp_type model_rsp;
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      model_rsp = list_apply(r);
      pending_rsp.push_back(typed ? typed_rsp : model_rsp);
      ops_sent++;
      if (!quiet && $urandom_range(3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(5))
         0: return MinInt;
         1: return MaxInt;
         2, 3: return $signed(32'($urandom_range(7))) - 32'sd3;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type pick_op(int bias);
      req_type r;
      int roll;
      roll = $urandom_range(99);
      r.value = pick_value();
      r.position = ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(list_len));
      if (roll < 2) r.opcode = 4'($urandom_range(OpUnusedHi, OpUnusedLo));
      else if (roll < 3) r.opcode = OP_CLEAR;
      else if (roll < 6) r.opcode = $urandom_range(0, 1) ? OP_SORT_UP : OP_SORT_DOWN;
      else if (roll < 16) r.opcode = OP_SEARCH;
      else if (roll < 22) r.opcode = OP_EXTREMES;
      else if (roll < 22 + bias) r.opcode = 4'($urandom_range(OP_INS_LAST, OP_INS_FIRST));
      else r.opcode = 4'($urandom_range(OP_DEL_LAST, OP_DEL_FIRST));
      return r;
   endfunction

   initial begin
      table_row_type steps [$];
      rsp_type none;
      int bias;
      none = '{status: ST_OK, read_value: '0, min_value: '0, found_index: '0, count: '0};
      steps = '{
         '{'{OP_DEL_FIRST, 32'sd0, 6'd0}, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 6'd0, 7'd0}},
         '{'{OP_DEL_AT, 32'sd0, 6'd0}, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 6'd0, 7'd0}},
         '{'{OP_DEL_LAST, 32'sd0, 6'd0}, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 6'd0, 7'd0}},
         '{'{OP_EXTREMES, 32'sd0, 6'd0}, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 6'd0, 7'd0}},
         '{'{OP_SEARCH, 32'sd5, 6'd0}, 1'b1, '{ST_NOTFOUND, 32'sd0, 32'sd0, 6'd0, 7'd0}},
         '{'{OP_SORT_UP, 32'sd0, 6'd0}, 1'b1, '{ST_OK, 32'sd0, 32'sd0, 6'd0, 7'd0}},
         '{'{OP_INS_AT, 32'sd9, 6'd1}, 1'b1, '{ST_BADIDX, 32'sd0, 32'sd0, 6'd0, 7'd0}},
         '{'{OP_INS_FIRST, MinInt, 6'd0}, 1'b1, '{ST_OK, 32'sd0, 32'sd0, 6'd0, 7'd1}},
         '{'{OP_SORT_DOWN, 32'sd0, 6'd0}, 1'b0, none},
         '{'{OP_INS_LAST, MaxInt, 6'd0}, 1'b1, '{ST_OK, 32'sd0, 32'sd0, 6'd0, 7'd2}},
         '{'{OP_INS_AT, -32'sd1, 6'd2}, 1'b1, '{ST_OK, 32'sd0, 32'sd0, 6'd0, 7'd3}},
         '{'{OP_INS_AT, 32'sd7, 6'd1}, 1'b0, none},
         '{'{OP_SEARCH, -32'sd1, 6'd0}, 1'b1, '{ST_OK, 32'sd0, 32'sd0, 6'd3, 7'd4}},
         '{'{OP_EXTREMES, 32'sd0, 6'd0}, 1'b1, '{ST_OK, MaxInt, MinInt, 6'd0, 7'd4}},
         '{'{OP_SORT_DOWN, 32'sd0, 6'd0}, 1'b0, none},
         '{'{OP_SORT_UP, 32'sd0, 6'd0}, 1'b0, none},
         '{'{OP_DEL_AT, 32'sd0, 6'd4}, 1'b1, '{ST_BADIDX, 32'sd0, 32'sd0, 6'd0, 7'd4}},
         '{'{OP_INS_AT, 32'sd0, 6'd63}, 1'b1, '{ST_BADIDX, 32'sd0, 32'sd0, 6'd0, 7'd4}},
         '{'{OP_DEL_AT, 32'sd0, 6'd1}, 1'b0, none},
         '{'{OP_DEL_LAST, 32'sd0, 6'd0}, 1'b0, none},
         '{'{OP_DEL_FIRST, 32'sd0, 6'd0}, 1'b0, none},
         '{'{OpUnusedLo, 32'sd0, 6'd0}, 1'b0, none},
         '{'{OpUnusedHi, 32'sd0, 6'd0}, 1'b0, none},
         '{'{OP_CLEAR, 32'sd0, 6'd0}, 1'b1, '{ST_OK, 32'sd0, 32'sd0, 6'd0, 7'd0}}
      };
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (steps[k]) send_op(steps[k].op, steps[k].typed, steps[k].rsp);
      bias = 40;
      for (int n = 0; n < RandomOps; n++) begin
         if (n % 60 == 0) bias = $urandom_range(2) == 0 ? 70 : $urandom_range(50, 30);
         if (n == RandomOps - QuietTail) quiet = 1'b1;
         send_op(pick_op(bias), 1'b0, none);
      end
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d list operations, %0d responses checked; lists were filled to", ops_sent,
               rsps_seen);
      $display("capacity and drained, with sorts, searches and error cases mixed in.");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(40, 1)) @(posedge clock);
         if (!quiet) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         rsps_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response transfer: %p", got);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, got.status);
               mismatches++;
            end
            if (got.read_value !== want.read_value) begin
               $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
               mismatches++;
            end
            if (got.min_value !== want.min_value) begin
               $error("min_value: expected %0d, actual %0d", want.min_value, got.min_value);
               mismatches++;
            end
            if (got.found_index !== want.found_index) begin
               $error("found_index: expected %0d, actual %0d", want.found_index,
                      got.found_index);
               mismatches++;
            end
            if (got.count !== want.count) begin
               $error("count: expected %0d, actual %0d", want.count, got.count);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses pending", cycles, pending_rsp.size());
         $display("end of test: mismatches");
         $finish;
      end
   end
endmodule
